// ----- hw/rtl/cms_pkg.sv -----
// ----------------------------------------------------------------------------
// cms_pkg: shared types and constants for the count-min sketch
// Field widths, opcodes, controller states and the hash unit status bundle.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int KEY_W       = 64;
    localparam int CNT_W       = 64;
    localparam int INC_W       = 32;
    localparam int SALT_REGS   = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int MAX_ROWS    = 4;
    localparam int ROWS_DEF    = 4;
    localparam int BUCKETS_DEF = 1024;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_DONE
    } cms_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cms_hash_stat_t;

endpackage

// ----- hw/rtl/cms_hash.sv -----
// ----------------------------------------------------------------------------
// cms_hash: per-row bucket index unit
// Computes (key ^ salt) mod BUCKETS for every row in parallel in three
// stages: fold the mixed hash bytes with weights 2^(8i) mod BUCKETS, take the
// quotient of the short sum by reciprocal multiplication, then subtract.
// ----------------------------------------------------------------------------
module cms_hash #(
    parameter int ROWS    = cms_pkg::ROWS_DEF,
    parameter int BUCKETS = cms_pkg::BUCKETS_DEF,
    localparam int AW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [cms_pkg::KEY_W-1:0]             key,
    input  logic [ROWS-1:0][cms_pkg::KEY_W-1:0]   salt,
    output logic [ROWS-1:0][AW-1:0]               bucket,
    output cms_pkg::cms_hash_stat_t               stat
);

    localparam int CHUNK_W = 8;
    localparam int CHUNKS  = cms_pkg::KEY_W / CHUNK_W;
    // each weighted byte is below 2^(CHUNK_W+AW); CHUNKS of them summed
    localparam int FOLD_W  = CHUNK_W + AW + $clog2(CHUNKS);
    localparam int SH_L    = $clog2(BUCKETS);
    localparam int RW      = FOLD_W + 1;
    localparam int PW      = FOLD_W + RW;
    localparam int SHIFT   = FOLD_W + SH_L;
    // ceil(2^SHIFT / BUCKETS): exact quotient for any FOLD_W-bit sum
    localparam logic [RW-1:0] RECIP_M =
        RW'(((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
    localparam logic [FOLD_W-1:0] DIVISOR = FOLD_W'(BUCKETS);

    function automatic logic [CHUNKS-1:0][AW-1:0] chunk_weights();
        logic [CHUNKS-1:0][AW-1:0] w;
        logic [63:0]               p;
        p = 64'd1 % 64'(BUCKETS);
        for (int i = 0; i < CHUNKS; i++)
        begin
            w[i] = AW'(p);
            p    = (p << CHUNK_W) % 64'(BUCKETS);
        end
        return w;
    endfunction

    localparam logic [CHUNKS-1:0][AW-1:0] WEIGHT = chunk_weights();

    logic [cms_pkg::KEY_W-1:0]   key_reg;
    logic [ROWS-1:0][FOLD_W-1:0] fold_reg, fold_next;
    logic [ROWS-1:0][FOLD_W-1:0] quot_reg, quot_next;
    logic [ROWS-1:0][AW-1:0]     rem_reg, rem_next;
    logic [2:0]                  stage_reg;
    logic                        done_reg;

    always_comb
    begin
        logic [cms_pkg::KEY_W-1:0] mixed;
        logic [FOLD_W-1:0]         acc;
        for (int r = 0; r < ROWS; r++)
        begin
            mixed = key_reg ^ salt[r];
            acc   = '0;
            for (int i = 0; i < CHUNKS; i++)
            begin
                acc = acc + FOLD_W'(mixed[i*CHUNK_W +: CHUNK_W]) * FOLD_W'(WEIGHT[i]);
            end
            fold_next[r] = acc;
        end
    end

    always_comb
    begin
        logic [PW-1:0] prod;
        for (int r = 0; r < ROWS; r++)
        begin
            prod         = PW'(fold_reg[r]) * PW'(RECIP_M);
            quot_next[r] = FOLD_W'(prod >> SHIFT);
        end
    end

    always_comb
    begin
        logic [FOLD_W-1:0] diff;
        for (int r = 0; r < ROWS; r++)
        begin
            diff        = fold_reg[r] - quot_reg[r] * DIVISOR;
            rem_next[r] = diff[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
        end
        if (stage_reg[0])
        begin
            fold_reg <= fold_next;
        end
        if (stage_reg[1])
        begin
            quot_reg <= quot_next;
        end
        if (stage_reg[2])
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            stage_reg <= 3'b001;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], 1'b0};
            if (stage_reg[2])
            begin
                done_reg <= 1'b1;
            end
        end
    end

    assign bucket    = rem_reg;
    assign stat.busy = |stage_reg;
    assign stat.done = done_reg;

endmodule

// ----- hw/rtl/cms_bank.sv -----
// ----------------------------------------------------------------------------
// cms_bank: counter memory for one sketch row
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cms_bank #(
    parameter int BUCKETS = cms_pkg::BUCKETS_DEF,
    localparam int AW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [cms_pkg::CNT_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [cms_pkg::CNT_W-1:0] rdata
);

    logic [cms_pkg::CNT_W-1:0] mem [BUCKETS];
    logic [cms_pkg::CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/count_min_sketch.sv -----
// ----------------------------------------------------------------------------
// count_min_sketch: Count-Min sketch over pre-hashed 64-bit keys
// Add beats bump one counter per row; query beats return the row minimum.
// ----------------------------------------------------------------------------
// After reset the block sweeps all row memories to zero, one bucket of every
// row per cycle, and s_tready stays low until the sweep is done; salt writes
// are taken during that time. One beat is handled at a time, so a new beat is
// taken only after the last one is through: the accept step, the bucket unit
// (byte fold, reciprocal multiply, remainder, hand-over; all rows in
// parallel), a memory read and a write-back or minimum step. A query result
// sits in an output register; a second query finishing while that result is
// still unread waits for m_tready. Load salts only while idle.
module count_min_sketch #(
    parameter int ROWS    = cms_pkg::ROWS_DEF,
    parameter int BUCKETS = cms_pkg::BUCKETS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [95:0]                    s_tdata,   // key_hash[63:0], increment[95:64]
    input  logic                           s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,   // estimate[63:0]
    input  logic                           cfg_we,
    input  logic [cms_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [63:0]                    cfg_wdata
);

    localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(BUCKETS - 1);

    cms_pkg::cms_state_t state_reg, state_next;

    logic [cms_pkg::KEY_W-1:0]            salt_reg [cms_pkg::SALT_REGS];
    logic [ROWS-1:0][cms_pkg::KEY_W-1:0]  row_salt;
    logic [AW-1:0]                        clr_addr_reg;
    logic                                 op_reg;
    logic [cms_pkg::INC_W-1:0]            inc_reg;
    logic                                 out_valid_reg;
    logic [cms_pkg::CNT_W-1:0]            est_reg;

    logic                                 hash_start;
    logic                                 mem_re;
    logic                                 mem_we;
    logic                                 clr_active;
    logic                                 out_load;
    logic                                 is_add;

    cms_pkg::cms_hash_stat_t              hstat;
    logic [ROWS-1:0][AW-1:0]              bucket;
    logic [ROWS-1:0][cms_pkg::CNT_W-1:0]  rd_data;
    logic [ROWS-1:0][AW-1:0]              wr_addr;
    logic [ROWS-1:0][cms_pkg::CNT_W-1:0]  wr_data;

    logic [cms_pkg::MAX_ROWS-1:0][cms_pkg::CNT_W-1:0] pad;
    logic [cms_pkg::CNT_W-1:0]            min01, min23, min_all;

    assign is_add = (op_reg == cms_pkg::OP_ADD);

    // ---------------- salt registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cms_pkg::SALT_REGS; i++)
            begin
                salt_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < cms_pkg::SALT_REGS; i++)
            begin
                if (cfg_addr == cms_pkg::CFG_ADDR_W'(i))
                begin
                    salt_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            row_salt[r] = salt_reg[r];
        end
    end

    // ---------------- controller ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cms_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = cms_pkg::ST_IDLE;
                end
            end
            cms_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = cms_pkg::ST_HASH;
                end
            end
            cms_pkg::ST_HASH:
            begin
                if (hstat.done)
                begin
                    state_next = cms_pkg::ST_READ;
                end
            end
            cms_pkg::ST_READ:
            begin
                state_next = cms_pkg::ST_DONE;
            end
            cms_pkg::ST_DONE:
            begin
                if (is_add || out_load)
                begin
                    state_next = cms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cms_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        clr_active = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            cms_pkg::ST_CLEAR:
            begin
                clr_active = 1'b1;
                mem_we     = 1'b1;
            end
            cms_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            cms_pkg::ST_HASH:
            begin
            end
            cms_pkg::ST_READ:
            begin
                mem_re = 1'b1;
            end
            cms_pkg::ST_DONE:
            begin
                mem_we   = is_add;
                out_load = (op_reg == cms_pkg::OP_QUERY) && (!out_valid_reg || m_tready);
            end
            default:
            begin
            end
        endcase
    end

    assign hash_start = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cms_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_active)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hash_start)
        begin
            op_reg  <= s_tuser;
            inc_reg <= s_tdata[95:64];
        end
    end

    // ---------------- bucket unit ----------------
    cms_hash #(
        .ROWS    (ROWS),
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (s_tdata[63:0]),
        .salt   (row_salt),
        .bucket (bucket),
        .stat   (hstat)
    );

    // ---------------- row memories ----------------
    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        assign wr_addr[r] = clr_active ? clr_addr_reg : bucket[r];
        assign wr_data[r] = clr_active ? '0
                          : rd_data[r] + cms_pkg::CNT_W'(inc_reg);

        cms_bank #(
            .BUCKETS (BUCKETS)
        ) u_bank (
            .clk   (clk),
            .we    (mem_we),
            .waddr (wr_addr[r]),
            .wdata (wr_data[r]),
            .re    (mem_re),
            .raddr (bucket[r]),
            .rdata (rd_data[r])
        );
    end

    // ---------------- minimum and result register ----------------
    // rows beyond ROWS read as all ones so they never win
    always_comb
    begin
        for (int i = 0; i < cms_pkg::MAX_ROWS; i++)
        begin
            pad[i] = '1;
        end
        for (int r = 0; r < ROWS; r++)
        begin
            pad[r] = rd_data[r];
        end
    end

    assign min01   = (pad[1] < pad[0]) ? pad[1] : pad[0];
    assign min23   = (pad[3] < pad[2]) ? pad[3] : pad[2];
    assign min_all = (min23 < min01) ? min23 : min01;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            est_reg <= min_all;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = est_reg;

`ifndef SYNTHESIS
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("row memory read and written in one cycle");

    a_ready_hash_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !hstat.busy)
        else $error("input ready while bucket unit busy");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> m_tready)
        else $error("pending result overwritten");

    a_hash_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cms_pkg::ST_HASH && hstat.done) |=> mem_re)
        else $error("bucket indices ready but no memory read");

    a_read_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == cms_pkg::ST_DONE))
        else $error("read data not consumed in the following cycle");
`endif

endmodule
